>>> sv/batched_direction_lane_arbiter_macros.svh
// Assertion macros used by the checker file of the lane arbiter.
`ifndef BATCHED_DIRECTION_LANE_ARBITER_MACROS_SVH
`define BATCHED_DIRECTION_LANE_ARBITER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BDLA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lane arbiter check failed");

// Next-cycle implication, disabled while reset is high.
`define BDLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lane arbiter check failed");

`endif

>>> sv/bdla_pkg.sv
package bdla_pkg;

  // Default maximum count of the per-side waiting counters.
  localparam int WAIT_COUNT_MAX_DEFAULT = 255;

  // Configuration register indexes.
  localparam logic [1:0] REG_BATCH_LIMIT   = 2'd0;
  localparam logic [1:0] REG_BATCH_MINIMUM = 2'd1;
  localparam logic [1:0] REG_LANE_CAPACITY = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] BATCH_LIMIT_RESET   = 8'd7;
  localparam logic [7:0] BATCH_MINIMUM_RESET = 8'd5;
  localparam logic [3:0] LANE_CAPACITY_RESET = 4'd5;

  // Event kinds.
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_FINISH  = 1'b1;

  // Sides and directions.
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_CROSSER = 2'd1;
  localparam logic [1:0] STATUS_WAIT_FULL  = 2'd2;

  // Saturation value of the batch counter.
  localparam logic [7:0] BATCH_SAT = 8'hFF;

endpackage

>>> sv/batched_direction_lane_arbiter.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------
// event    | in        | in_valid / in_stall | mode, side
// result   | out       | out_valid/out_stall | granted_count, granted_side, handover,
//          |           |                     | current_direction, batch_now, status
// config   | in        | cfg_write           | cfg_index, cfg_data
//
// Each event is settled in the cycle it is accepted; its result appears in the
// output register in the next cycle. One event per cycle is sustained unless stalled.
// in_stall is high only while the output register holds a result that is stalled.
// Reset (synchronous) clears the counters and direction and loads the register defaults.
module batched_direction_lane_arbiter #(
  parameter int WAIT_COUNT_MAX = bdla_pkg::WAIT_COUNT_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic       side,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] granted_count,
  output logic       granted_side,
  output logic       handover,
  output logic       current_direction,
  output logic [7:0] batch_now,
  output logic [1:0] status,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import bdla_pkg::*;

  localparam int WW = $clog2(WAIT_COUNT_MAX + 1);
  localparam int GW = (WW > 8) ? WW : 8;
  localparam logic [WW-1:0] WAIT_FULL = WW'(WAIT_COUNT_MAX);

  // Configuration registers.
  logic [7:0] batch_limit;
  logic [7:0] batch_minimum;
  logic [3:0] lane_capacity;

  // Arbiter state.
  logic          dir_reg;
  logic [7:0]    batch_counter;
  logic [WW-1:0] waiting_left;
  logic [WW-1:0] waiting_right;
  logic [3:0]    crossing_left;
  logic [3:0]    crossing_right;

  // Next-state and result values.
  logic          dir_next;
  logic [7:0]    batch_counter_next;
  logic [WW-1:0] waiting_left_next;
  logic [WW-1:0] waiting_right_next;
  logic [3:0]    crossing_left_next;
  logic [3:0]    crossing_right_next;
  logic [3:0]    grant;
  logic          switch_dir;
  logic [1:0]    status_next;

  logic [WW-1:0] wl_ev, wr_ev, wd, wo, wd2, wo2;
  logic [3:0]    cl_ev, cr_ev, cd2, co2, room;
  logic [7:0]    bc2, limit_room;
  logic [GW-1:0] grant_wide;
  logic [8:0]    batch_sum;
  logic          accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_limit   <= BATCH_LIMIT_RESET;
      batch_minimum <= BATCH_MINIMUM_RESET;
      lane_capacity <= LANE_CAPACITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BATCH_LIMIT:   batch_limit   <= cfg_data;
        REG_BATCH_MINIMUM: batch_minimum <= cfg_data;
        REG_LANE_CAPACITY: lane_capacity <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Count the event, then settle the lane: handover test, then closed-form grant.
  always_comb begin
    wl_ev       = waiting_left;
    wr_ev       = waiting_right;
    cl_ev       = crossing_left;
    cr_ev       = crossing_right;
    status_next = STATUS_OK;

    if (mode == MODE_ARRIVAL) begin
      if (side == SIDE_RIGHT) begin
        if (waiting_right >= WAIT_FULL) status_next = STATUS_WAIT_FULL;
        else wr_ev = waiting_right + WW'(1);
      end else begin
        if (waiting_left >= WAIT_FULL) status_next = STATUS_WAIT_FULL;
        else wl_ev = waiting_left + WW'(1);
      end
    end else begin
      if (side == SIDE_RIGHT) begin
        if (crossing_right == 4'd0) status_next = STATUS_NO_CROSSER;
        else cr_ev = crossing_right - 4'd1;
      end else begin
        if (crossing_left == 4'd0) status_next = STATUS_NO_CROSSER;
        else cl_ev = crossing_left - 4'd1;
      end
    end

    // Handover on an empty lane.
    wd = (dir_reg == SIDE_RIGHT) ? wr_ev : wl_ev;
    wo = (dir_reg == SIDE_RIGHT) ? wl_ev : wr_ev;
    switch_dir = (cl_ev == 4'd0) && (cr_ev == 4'd0) && (wo != '0) &&
                 ((batch_counter >= batch_minimum) || (wd == '0) ||
                  (batch_counter >= batch_limit));
    dir_next = dir_reg ^ switch_dir;
    bc2      = switch_dir ? 8'd0 : batch_counter;

    wd2 = (dir_next == SIDE_RIGHT) ? wr_ev : wl_ev;
    wo2 = (dir_next == SIDE_RIGHT) ? wl_ev : wr_ev;
    cd2 = (dir_next == SIDE_RIGHT) ? cr_ev : cl_ev;
    co2 = (dir_next == SIDE_RIGHT) ? cl_ev : cr_ev;

    // Grant limited by waiting users, free room and, if contested, the batch limit.
    room       = (lane_capacity > cd2) ? (lane_capacity - cd2) : 4'd0;
    limit_room = (batch_limit > bc2) ? (batch_limit - bc2) : 8'd0;
    grant_wide = GW'(wd2);
    if (GW'(room) < grant_wide) grant_wide = GW'(room);
    if ((wo2 != '0) && (GW'(limit_room) < grant_wide)) grant_wide = GW'(limit_room);
    if (co2 != 4'd0) grant_wide = '0;
    grant = grant_wide[3:0];

    batch_sum          = {1'b0, bc2} + 9'(grant);
    batch_counter_next = batch_sum[8] ? BATCH_SAT : batch_sum[7:0];

    waiting_left_next   = wl_ev;
    waiting_right_next  = wr_ev;
    crossing_left_next  = cl_ev;
    crossing_right_next = cr_ev;
    if (dir_next == SIDE_RIGHT) begin
      waiting_right_next  = wr_ev - WW'(grant_wide);
      crossing_right_next = cr_ev + grant;
    end else begin
      waiting_left_next  = wl_ev - WW'(grant_wide);
      crossing_left_next = cl_ev + grant;
    end
  end

  // State update on each accepted event.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_reg        <= SIDE_LEFT;
      batch_counter  <= 8'd0;
      waiting_left   <= '0;
      waiting_right  <= '0;
      crossing_left  <= 4'd0;
      crossing_right <= 4'd0;
    end else if (accept) begin
      dir_reg        <= dir_next;
      batch_counter  <= batch_counter_next;
      waiting_left   <= waiting_left_next;
      waiting_right  <= waiting_right_next;
      crossing_left  <= crossing_left_next;
      crossing_right <= crossing_right_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      granted_count     <= grant;
      granted_side      <= dir_next;
      handover          <= switch_dir;
      current_direction <= dir_next;
      batch_now         <= batch_counter_next;
      status            <= status_next;
    end
  end

endmodule

>>> sv/bdla_checker.sv
`include "batched_direction_lane_arbiter_macros.svh"

module bdla_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] granted_count,
  input logic       granted_side,
  input logic       handover,
  input logic       current_direction,
  input logic [7:0] batch_now,
  input logic [1:0] status
);
  import bdla_pkg::*;

  // A stalled result keeps its transaction unchanged.
  `BDLA_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(granted_count) && $stable(batch_now) && $stable(status))

  // Grants always go to the direction that holds the lane after the event.
  `BDLA_ASSERT_NOW(a_side_is_dir, clk, rst, out_valid, granted_side == current_direction)

  // A handover restarts the batch, so the batch equals this event's grant.
  `BDLA_ASSERT_NOW(a_handover_batch, clk, rst, out_valid && handover,
    batch_now == {4'd0, granted_count})

  // Only the three defined status codes appear.
  `BDLA_ASSERT_NOW(a_status_code, clk, rst, out_valid,
    status == STATUS_OK || status == STATUS_NO_CROSSER || status == STATUS_WAIT_FULL)

endmodule

bind batched_direction_lane_arbiter bdla_checker u_bdla_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .granted_count     (granted_count),
  .granted_side      (granted_side),
  .handover          (handover),
  .current_direction (current_direction),
  .batch_now         (batch_now),
  .status            (status)
);
